// ===== hdl/oct_pkg.sv =====
// oct_pkg: shared types and constants of the outstanding command tracker
// no dependencies
`default_nettype none
package oct_pkg;
    localparam int SLOTS = 16;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_RESP = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    localparam logic [2:0] EV_SENT    = 3'd0;
    localparam logic [2:0] EV_NO_SLOT = 3'd1;
    localparam logic [2:0] EV_MATCHED = 3'd2;
    localparam logic [2:0] EV_UNKNOWN = 3'd3;
    localparam logic [2:0] EV_RETRY   = 3'd4;
    localparam logic [2:0] EV_EXPIRED = 3'd5;

    localparam logic [0:0] REG_DEFAULT_TIMEOUT = 1'd0;
    localparam logic [0:0] REG_MAX_RETRIES     = 1'd1;

    // request presented to every cell in turn
    typedef struct packed {
        logic        run;
        logic [1:0]  command;
        logic [7:0]  cmd_id;
        logic [15:0] timeout;
        logic [3:0]  retries;
        logic [7:0]  resp_seq;
        logic [31:0] now;
        logic [7:0]  seq_no;
    } oct_req_t;

    // token handed along the row: still looking for a free slot / match
    typedef struct packed {
        logic pending;
    } oct_tok_t;

    // cell event report
    typedef struct packed {
        logic        hit;
        logic [2:0]  ev;
        logic [7:0]  seq;
        logic [7:0]  cmd;
        logic [3:0]  retries;
    } oct_rep_t;
endpackage
`default_nettype wire

// ===== hdl/oct_cell.sv =====
// oct_cell: one slot of the tracker table
// depends on oct_pkg
`default_nettype none
module oct_cell
    import oct_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     sel,
    input  wire oct_req_t req,
    input  wire oct_tok_t tok_in,
    output oct_tok_t      tok_out,
    output oct_rep_t      rep
);
    logic        valid_reg;
    logic [7:0]  seq_reg;
    logic [7:0]  cmd_reg;
    logic [31:0] sent_reg;
    logic [15:0] tmo_reg;
    logic [3:0]  ret_reg;
    logic [31:0] elapsed;
    logic        take, match, expire;

    // decisions for this slot on its turn
    always_comb
    begin
        elapsed = req.now - sent_reg;
        take    = sel && req.command == CMD_SEND && tok_in.pending && !valid_reg;
        match   = sel && req.command == CMD_RESP && tok_in.pending && valid_reg
                  && seq_reg == req.resp_seq;
        expire  = sel && req.command == CMD_TICK && valid_reg
                  && elapsed > {16'd0, tmo_reg};
        tok_out.pending = tok_in.pending && !take && !match;
        rep.hit = take || match || expire;
        rep.seq = take ? req.seq_no : seq_reg;
        rep.cmd = take ? req.cmd_id : cmd_reg;
        if (take)
        begin
            rep.ev = EV_SENT;
            rep.retries = req.retries;
        end
        else if (match)
        begin
            rep.ev = EV_MATCHED;
            rep.retries = ret_reg;
        end
        else if (ret_reg != 4'd0)
        begin
            rep.ev = EV_RETRY;
            rep.retries = ret_reg - 4'd1;
        end
        else
        begin
            rep.ev = EV_EXPIRED;
            rep.retries = 4'd0;
        end
    end

    // slot valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (match || (expire && ret_reg == 4'd0))
            valid_reg <= 1'b0;
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            seq_reg  <= req.seq_no;
            cmd_reg  <= req.cmd_id;
            sent_reg <= req.now;
            tmo_reg  <= req.timeout;
            ret_reg  <= req.retries;
        end
        else if (expire && ret_reg != 4'd0)
        begin
            ret_reg  <= ret_reg - 4'd1;
            sent_reg <= req.now;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/outstanding_command_tracker_core.sv =====
// outstanding_command_tracker_core: top level, request sequencer and result register
// depends on oct_pkg and oct_cell
//
// Input requests on s_axis: command in tuser, id, timeout, response seq/status
// and time in tdata. Results on m_axis: event in tuser, the rest in tdata,
// tlast marks the final result of a request.
// Configuration writes on cfg: index 0 default timeout, 1 retry budget.
// Each request walks along the row of SLOTS slot cells, one cell per cycle while not paused.
// A send or response that finds slot k has its result registered as the walk
// reaches slot k; no free slot or an unknown seq is reported at the last cell.
// A tick gives up to SLOTS results (none if nothing timed out); each is held
// back until the next one or the end of the walk to learn tlast. The next
// request is accepted the cycle after the final result is registered, so a new
// request is not taken while one is walking or a tick result is held.
// The walk pauses while a result waits in the output register and the
// receiver stalls; s_axis_tready is high only between requests.
// Reset empties the table, sets sequence number 1 and register defaults.
`default_nettype none
module outstanding_command_tracker_core
    import oct_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // cmd_id[7:0] timeout[23:8] resp_seq[31:24] resp_status[39:32] now_ms[71:40]
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // event_res[2:0]
    output logic [2:0]       m_axis_tuser,
    // slot[3:0] seq[11:4] cmd_out[19:12] status_out[27:20] retries_remaining[31:28]
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic [15:0]      dflt_reg;
    logic [3:0]       maxr_reg;
    logic [7:0]       nseq_reg;
    logic             busy_reg;
    logic [SLOT_W-1:0] idx_reg;
    oct_req_t         req_reg;
    logic [7:0]       status_reg;
    logic             seen_reg;
    logic             hold_reg;   // a tick result held back to learn tlast
    logic [34:0]      hold_data_reg;

    oct_tok_t tok [SLOTS+1];
    oct_rep_t rep [SLOTS];
    oct_rep_t cur;
    logic     stall, step, endw;
    logic [34:0] pk;
    logic [3:0]  slot4;
    logic        out_load, out_last;
    logic [34:0] out_word;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = !busy_reg && !hold_reg;
    assign stall = m_axis_tvalid && !m_axis_tready;
    assign step = busy_reg && !stall;
    assign endw = idx_reg == SLOT_W'(SLOTS - 1);

    // row of slot cells
    assign tok[0].pending = req_reg.run;
    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            oct_cell u_cell (
                .clk(clk), .rst_n(rst_n),
                .sel(step && idx_reg == SLOT_W'(g)),
                .req(req_reg), .tok_in(tok[g]), .tok_out(tok[g+1]), .rep(rep[g])
            );
        end
    endgenerate

    // report of the addressed cell, {retries, status, cmd, seq, slot, event}
    always_comb
    begin
        cur = rep[idx_reg];
        slot4 = 4'(idx_reg);
        pk = {cur.retries, (cur.ev == EV_MATCHED) ? status_reg : 8'd0,
              cur.cmd, cur.seq, slot4, cur.ev};
    end

    // what goes into the result register this cycle
    always_comb
    begin
        out_load = 1'b0;
        out_last = 1'b1;
        out_word = hold_data_reg;
        if (step)
        begin
            if (req_reg.command == CMD_TICK)
            begin
                out_load = cur.hit && hold_reg;
                out_last = 1'b0;
            end
            else if (cur.hit && !seen_reg)
            begin
                out_load = 1'b1;
                out_word = pk;
            end
            else if (endw)
            begin
                out_load = 1'b1;
                if (req_reg.command == CMD_SEND)
                    out_word = {4'd0, 8'd0, req_reg.cmd_id, 8'd0, 4'd0, EV_NO_SLOT};
                else
                    out_word = {4'd0, 8'd0, 8'd0, req_reg.resp_seq, 4'd0, EV_UNKNOWN};
            end
        end
        else if (!busy_reg && hold_reg && !stall)
        begin
            // flush the final tick result
            out_load = 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_reg <= 16'd1000;
            maxr_reg <= 4'd3;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_DEFAULT_TIMEOUT)
                dflt_reg <= cfg_data;
            else
                maxr_reg <= cfg_data[3:0];
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
            nseq_reg <= 8'd1;
            m_axis_tvalid <= 1'b0;
            m_axis_tlast <= 1'b0;
            m_axis_tdata <= '0;
            m_axis_tuser <= '0;
            req_reg <= '0;
            status_reg <= 8'd0;
            seen_reg <= 1'b0;
            hold_reg <= 1'b0;
            hold_data_reg <= '0;
        end
        else
        begin
            if (out_load)
            begin
                m_axis_tvalid <= 1'b1;
                m_axis_tdata <= out_word[34:3];
                m_axis_tuser <= out_word[2:0];
                m_axis_tlast <= out_last;
            end
            else if (m_axis_tready)
                m_axis_tvalid <= 1'b0;

            if (s_axis_tvalid && s_axis_tready)
            begin
                busy_reg <= s_axis_tuser != CMD_NOP;
                idx_reg <= '0;
                req_reg.run <= 1'b1;
                req_reg.command <= s_axis_tuser;
                req_reg.cmd_id <= s_axis_tdata[7:0];
                req_reg.timeout <= (s_axis_tdata[23:8] == 16'd0) ? dflt_reg
                                                                 : s_axis_tdata[23:8];
                req_reg.retries <= maxr_reg;
                req_reg.resp_seq <= s_axis_tdata[31:24];
                req_reg.now <= s_axis_tdata[71:40];
                req_reg.seq_no <= nseq_reg;
                status_reg <= s_axis_tdata[39:32];
                seen_reg <= 1'b0;
                hold_reg <= 1'b0;
            end
            else if (step)
            begin
                if (req_reg.command == CMD_TICK)
                begin
                    if (cur.hit)
                    begin
                        hold_reg <= 1'b1;
                        hold_data_reg <= pk;
                    end
                    if (endw)
                        busy_reg <= 1'b0;
                end
                else if (cur.hit && !seen_reg)
                begin
                    seen_reg <= 1'b1;
                    if (req_reg.command == CMD_SEND)
                        nseq_reg <= (nseq_reg == 8'd255) ? 8'd1 : nseq_reg + 8'd1;
                    busy_reg <= 1'b0;
                end
                else if (endw)
                    busy_reg <= 1'b0;
                if (!endw)
                    idx_reg <= idx_reg + SLOT_W'(1);
            end
            else if (!busy_reg && hold_reg && !stall)
                hold_reg <= 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_seq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        nseq_reg != 8'd0) else $error("sequence number zero");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_axis_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> m_axis_tvalid) else $error("result dropped");
`endif
endmodule
`default_nettype wire
